FILE: src/bfv_pkg.sv
// bfv_pkg: shared widths, types and constants of the box visibility block
// used by bfv_products, bfv_lane and box_frustum_visibility; no dependencies
package bfv_pkg;

    // field and register widths
    localparam int COORD_WIDTH  = 32;
    localparam int MATRIX_WIDTH = 16;
    localparam int CORNER_COUNT = 8;
    localparam int COORD_FRAC   = 16;
    localparam int CFG_WIDTH    = 32;
    localparam int REG_COUNT    = 6;
    localparam int REG_IDX_W    = $clog2(REG_COUNT);
    localparam int CORNER_SEL_W = $clog2(CORNER_COUNT);

    // matrix rows held (x, y, w) and box axes
    localparam int ROW_COUNT  = 3;
    localparam int AXIS_COUNT = 3;
    localparam int ROW_X      = 0;
    localparam int ROW_Y      = 1;
    localparam int ROW_W      = 2;
    localparam int AXIS_X     = 0;
    localparam int AXIS_Y     = 1;
    localparam int AXIS_Z     = 2;

    // product and accumulator widths, exact for three products plus the offset
    localparam int PROD_W = COORD_WIDTH + MATRIX_WIDTH;
    localparam int ACC_W  = PROD_W + 2;

    // register map
    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROW_X_01 = REG_IDX_W'(0),
        REG_ROW_X_23 = REG_IDX_W'(1),
        REG_ROW_Y_01 = REG_IDX_W'(2),
        REG_ROW_Y_23 = REG_IDX_W'(3),
        REG_ROW_W_01 = REG_IDX_W'(4),
        REG_ROW_W_23 = REG_IDX_W'(5)
    } reg_index_t;

    // reset values: identity in x, y and w
    localparam logic [CFG_WIDTH-1:0] RST_ROW_X_01 = 32'h0000_1000;
    localparam logic [CFG_WIDTH-1:0] RST_ROW_X_23 = 32'h0000_0000;
    localparam logic [CFG_WIDTH-1:0] RST_ROW_Y_01 = 32'h1000_0000;
    localparam logic [CFG_WIDTH-1:0] RST_ROW_Y_23 = 32'h0000_0000;
    localparam logic [CFG_WIDTH-1:0] RST_ROW_W_01 = 32'h0000_0000;
    localparam logic [CFG_WIDTH-1:0] RST_ROW_W_23 = 32'h1000_0000;

    typedef logic signed [COORD_WIDTH-1:0]  coord_t;
    typedef logic signed [MATRIX_WIDTH-1:0] matrix_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [ACC_W-1:0]        acc_t;
    typedef logic [ACC_W-1:0]               mag_t;
    typedef logic [CORNER_SEL_W-1:0]        corner_t;

    typedef logic [REG_COUNT-1:0][CFG_WIDTH-1:0]            cfg_bank_t;
    typedef logic [AXIS_COUNT-1:0][COORD_WIDTH-1:0]         coord_vec_t;
    typedef logic [ROW_COUNT-1:0][AXIS_COUNT-1:0][1:0][PROD_W-1:0] prod_set_t;
    typedef logic [ROW_COUNT-1:0][ACC_W-1:0]                offset_set_t;

    // stage enables for the lanes
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_en_t;

    // matrix entry: low or high half of a 32-bit register
    function automatic matrix_t get_entry(input logic [CFG_WIDTH-1:0] r, input logic hi);
        logic [CFG_WIDTH-1:0] v;
        v = hi ? (r >> MATRIX_WIDTH) : r;
        return matrix_t'(v[MATRIX_WIDTH-1:0]);
    endfunction

    // sign extend a product to accumulator width
    function automatic acc_t ext_prod(input logic [PROD_W-1:0] p);
        return acc_t'({{(ACC_W-PROD_W){p[PROD_W-1]}}, p});
    endfunction

endpackage

FILE: src/bfv_products.sv
// bfv_products: first pipeline stage, all distinct matrix-by-coordinate products
// depends on bfv_pkg; shared by the eight corner lanes
module bfv_products
    import bfv_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  cfg_bank_t   cfg_regs,
    input  coord_vec_t  box_lo,
    input  coord_vec_t  box_hi,
    output prod_set_t   prods,
    output offset_set_t offsets
);

    prod_set_t   prods_reg;
    offset_set_t offsets_reg;

    // each row and axis needs one product with the min and one with the max coordinate
    for (genvar r = 0; r < ROW_COUNT; r++) begin : g_row
        for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_axis
            matrix_t m;
            assign m = get_entry(cfg_regs[2*r + a/2], 1'(a % 2));

            always_ff @(posedge aclk) begin
                if (en) begin
                    prods_reg[r][a][0] <= $signed(m) * $signed(box_lo[a]);
                    prods_reg[r][a][1] <= $signed(m) * $signed(box_hi[a]);
                end
            end
        end

        // column 3 times the homogeneous 1.0
        matrix_t m3;
        acc_t    m3_ext;
        assign m3     = get_entry(cfg_regs[2*r + 1], 1'b1);
        assign m3_ext = acc_t'({{(ACC_W-MATRIX_WIDTH){m3[MATRIX_WIDTH-1]}}, m3});

        always_ff @(posedge aclk) begin
            if (en) begin
                offsets_reg[r] <= m3_ext <<< COORD_FRAC;
            end
        end
    end

    assign prods   = prods_reg;
    assign offsets = offsets_reg;

endmodule

FILE: src/bfv_lane.sv
// bfv_lane: one corner lane, dot-product sums, magnitudes and clip compare
// depends on bfv_pkg; fed by bfv_products, merged in box_frustum_visibility
module bfv_lane
    import bfv_pkg::*;
(
    input  logic        aclk,
    input  pipe_en_t    en,
    input  corner_t     corner,
    input  prod_set_t   prods,
    input  offset_set_t offsets,
    output logic        in_clip
);

    acc_t [ROW_COUNT-1:0] sum_a_reg;
    acc_t [ROW_COUNT-1:0] sum_b_reg;
    acc_t [ROW_COUNT-1:0] sum_reg;
    mag_t [ROW_COUNT-1:0] mag_reg;
    logic                 in_clip_reg;

    // per-row sums and magnitudes
    for (genvar r = 0; r < ROW_COUNT; r++) begin : g_row
        acc_t px;
        acc_t py;
        acc_t pz;
        assign px = ext_prod(prods[r][AXIS_X][corner[0]]);
        assign py = ext_prod(prods[r][AXIS_Y][corner[1]]);
        assign pz = ext_prod(prods[r][AXIS_Z][corner[2]]);

        always_ff @(posedge aclk) begin
            // pairwise add
            if (en.s2) begin
                sum_a_reg[r] <= px + py;
                sum_b_reg[r] <= pz + $signed(offsets[r]);
            end
            // final add
            if (en.s3) begin
                sum_reg[r] <= sum_a_reg[r] + sum_b_reg[r];
            end
            // absolute value
            if (en.s4) begin
                mag_reg[r] <= sum_reg[r][ACC_W-1] ? mag_t'(-sum_reg[r]) : mag_t'(sum_reg[r]);
            end
        end
    end

    // clip compare, zero w is outside
    always_ff @(posedge aclk) begin
        if (en.s5) begin
            in_clip_reg <= (mag_reg[ROW_W] != '0)
                        && (mag_reg[ROW_X] <= mag_reg[ROW_W])
                        && (mag_reg[ROW_Y] <= mag_reg[ROW_W]);
        end
    end

    assign in_clip = in_clip_reg;

endmodule

FILE: src/box_frustum_visibility.sv
// box_frustum_visibility: top level, config registers, pipeline control and merge
// depends on bfv_pkg, bfv_products and bfv_lane
//
// Usage:
//   Input channel s_*: one request carries the min and max corners of a box,
//   signed Q16.16. Output channel m_*: one request per box, m_visible = 1 when
//   all eight corners transformed by the x, y and w matrix rows satisfy
//   |x| <= |w| and |y| <= |w| with w nonzero.
//   Config port: cfg_wr_en writes cfg_data to register cfg_index at the clock
//   edge; unknown indexes are ignored. Write only while no box is in flight.
//   From input accept to m_valid a box passes six registers (product stage,
//   two add stages, magnitude, compare, merge into the output).
//   Throughput: one box per cycle unless the receiver stalls, set by the eight
//   parallel corner lanes and the shared product stage of eighteen multipliers.
//   Each stage holds its own valid bit, so when the receiver stalls the
//   pipeline keeps filling its empty stages and s_ready drops only once
//   every stage holds a box.
//   Reset (aresetn low, synchronous) empties the pipeline and loads the
//   identity matrix into the x, y and w rows.
module box_frustum_visibility
    import bfv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]  cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  coord_t                s_box_min_x,
    input  coord_t                s_box_min_y,
    input  coord_t                s_box_min_z,
    input  coord_t                s_box_max_x,
    input  coord_t                s_box_max_y,
    input  coord_t                s_box_max_z,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_visible
);

    cfg_bank_t                 cfg_regs_reg;
    logic                      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                      m_valid_reg;
    logic                      m_visible_reg;
    logic                      en1, en2, en3, en4, en5, en_out;
    pipe_en_t                  lane_en;
    coord_vec_t                box_lo;
    coord_vec_t                box_hi;
    prod_set_t                 prods;
    offset_set_t               offsets;
    logic [CORNER_COUNT-1:0]   lane_inside;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_regs_reg[REG_ROW_X_01] <= RST_ROW_X_01;
            cfg_regs_reg[REG_ROW_X_23] <= RST_ROW_X_23;
            cfg_regs_reg[REG_ROW_Y_01] <= RST_ROW_Y_01;
            cfg_regs_reg[REG_ROW_Y_23] <= RST_ROW_Y_23;
            cfg_regs_reg[REG_ROW_W_01] <= RST_ROW_W_01;
            cfg_regs_reg[REG_ROW_W_23] <= RST_ROW_W_23;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROW_X_01: cfg_regs_reg[REG_ROW_X_01] <= cfg_data;
                REG_ROW_X_23: cfg_regs_reg[REG_ROW_X_23] <= cfg_data;
                REG_ROW_Y_01: cfg_regs_reg[REG_ROW_Y_01] <= cfg_data;
                REG_ROW_Y_23: cfg_regs_reg[REG_ROW_Y_23] <= cfg_data;
                REG_ROW_W_01: cfg_regs_reg[REG_ROW_W_01] <= cfg_data;
                REG_ROW_W_23: cfg_regs_reg[REG_ROW_W_23] <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables: a stage moves when empty or when the next one moves
    assign en_out  = !m_valid_reg || m_ready;
    assign en5     = !v5_reg || en_out;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    assign lane_en.s2 = en2;
    assign lane_en.s3 = en3;
    assign lane_en.s4 = en4;
    assign lane_en.s5 = en5;

    // stage valid bits and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1)    v1_reg      <= s_valid;
            if (en2)    v2_reg      <= v1_reg;
            if (en3)    v3_reg      <= v2_reg;
            if (en4)    v4_reg      <= v3_reg;
            if (en5)    v5_reg      <= v4_reg;
            if (en_out) m_valid_reg <= v5_reg;
        end
    end

    // merge: all corners inside
    always_ff @(posedge aclk) begin
        if (en_out) begin
            m_visible_reg <= &lane_inside;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_visible = m_visible_reg;

    assign box_lo[AXIS_X] = s_box_min_x;
    assign box_lo[AXIS_Y] = s_box_min_y;
    assign box_lo[AXIS_Z] = s_box_min_z;
    assign box_hi[AXIS_X] = s_box_max_x;
    assign box_hi[AXIS_Y] = s_box_max_y;
    assign box_hi[AXIS_Z] = s_box_max_z;

    // shared products
    bfv_products u_products (
        .aclk     (aclk),
        .en       (en1),
        .cfg_regs (cfg_regs_reg),
        .box_lo   (box_lo),
        .box_hi   (box_hi),
        .prods    (prods),
        .offsets  (offsets)
    );

    // one lane per corner
    for (genvar i = 0; i < CORNER_COUNT; i++) begin : g_lane
        bfv_lane u_lane (
            .aclk    (aclk),
            .en      (lane_en),
            .corner  (corner_t'(i)),
            .prods   (prods),
            .offsets (offsets),
            .in_clip (lane_inside[i])
        );
    end

    // an unstalled output means the whole pipeline can take a request
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg || m_ready) |-> s_ready)
        else $error("s_ready low while the output is free");

    // an accepted request occupies the first stage
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted request lost at the first stage");

    // the output loads the merge of the lane flags
    a_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        (v5_reg && en_out) |=> (m_valid_reg && (m_visible_reg == $past(&lane_inside))))
        else $error("output does not hold the merged lane result");

    // reset empties the output
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("output valid after reset");

endmodule

FILE: verif/tb.sv
// tb: self-checking testbench for box_frustum_visibility, the clip-space box cull
// depends on bfv_pkg for widths, register indexes and reset values; predicts each
// box from its own copy of the matrix registers and checks every m_visible in order
module tb
    import bfv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE_Q12 = 4096;
    localparam int ONE_Q16 = 1 << COORD_FRAC;
    localparam int SPAN = 2 * ONE_Q16;
    localparam int EXT_MAX = ONE_Q16 / 2;
    localparam int PHASE_ITEMS = 116;
    localparam int HOLD_CYCLES = 400;
    localparam int PIPE_LATENCY = 6;
    // longest quiet stretch is the receiver hold-off plus a pipeline refill
    localparam int WATCHDOG_LIMIT = 3000;

    localparam coord_t C_MAX = 32'sh7FFF_FFFF;
    localparam coord_t C_MIN = 32'sh8000_0000;
    localparam logic [REG_IDX_W-1:0] IDX_SPARE_FIRST = REG_IDX_W'(REG_COUNT);
    localparam logic [REG_IDX_W-1:0] IDX_SPARE_LAST = '1;

    typedef struct {
        coord_t lo [AXIS_COUNT];
        coord_t hi [AXIS_COUNT];
    } box_t;

    // matrix mirror, visibility predictor and in-order result check
    class visibility_scoreboard;
        logic [CFG_WIDTH-1:0] regs [REG_COUNT];
        bit expected_q [$];
        int checked;
        int visible_seen;
        int failures;

        function new();
            regs[REG_ROW_X_01] = RST_ROW_X_01;
            regs[REG_ROW_X_23] = RST_ROW_X_23;
            regs[REG_ROW_Y_01] = RST_ROW_Y_01;
            regs[REG_ROW_Y_23] = RST_ROW_Y_23;
            regs[REG_ROW_W_01] = RST_ROW_W_01;
            regs[REG_ROW_W_23] = RST_ROW_W_23;
        endfunction

        // writes to unused indexes are dropped
        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_WIDTH-1:0] val);
            if (idx < REG_COUNT)
                regs[idx] = val;
        endfunction

        // entry col of a row: even cols in the low half, odd in the high half
        function longint entry(int row, int col);
            logic [CFG_WIDTH-1:0] r;
            matrix_t m;
            r = regs[2 * row + col / 2];
            m = r[MATRIX_WIDTH * (col % 2) +: MATRIX_WIDTH];
            return longint'(m);
        endfunction

        // row times (cx, cy, cz, 1.0) in Q.28, exact in 64 bits
        function longint row_dot(int row, longint cx, longint cy, longint cz);
            return entry(row, 0) * cx + entry(row, 1) * cy + entry(row, 2) * cz
                + entry(row, 3) * (longint'(1) <<< COORD_FRAC);
        endfunction

        function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // all eight corners must satisfy |x| <= |w|, |y| <= |w|, w nonzero
        function bit box_visible(box_t b);
            longint cx, cy, cz, tx, ty, tw;
            bit vis;
            vis = 1'b1;
            for (int c = 0; c < CORNER_COUNT; c++) begin
                cx = (c & 1) ? longint'(b.hi[AXIS_X]) : longint'(b.lo[AXIS_X]);
                cy = (c & 2) ? longint'(b.hi[AXIS_Y]) : longint'(b.lo[AXIS_Y]);
                cz = (c & 4) ? longint'(b.hi[AXIS_Z]) : longint'(b.lo[AXIS_Z]);
                tx = magnitude(row_dot(ROW_X, cx, cy, cz));
                ty = magnitude(row_dot(ROW_Y, cx, cy, cz));
                tw = magnitude(row_dot(ROW_W, cx, cy, cz));
                if (tw == 0 || tx > tw || ty > tw)
                    vis = 1'b0;
            end
            return vis;
        endfunction

        function void note_box(box_t b);
            expected_q.push_back(box_visible(b));
        endfunction

        function void check_result(logic vis);
            bit want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: visible %0b with no box pending", vis);
                failures++;
            end else begin
                want = expected_q.pop_front();
                checked++;
                if (vis === 1'b1)
                    visible_seen++;
                if (vis !== want) begin
                    $error("visible mismatch: expected %0b, actual %0b", want, vis);
                    failures++;
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_box_min_x = '0;
    coord_t s_box_min_y = '0;
    coord_t s_box_min_z = '0;
    coord_t s_box_max_x = '0;
    coord_t s_box_max_y = '0;
    coord_t s_box_max_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_visible;

    logic rx_hold = 1'b0;
    int rx_stall_pct = 0;
    int idle_cycles = 0;
    int settings_used = 0;
    visibility_scoreboard sb;

    box_frustum_visibility dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_box_min_x(s_box_min_x),
        .s_box_min_y(s_box_min_y),
        .s_box_min_z(s_box_min_z),
        .s_box_max_x(s_box_max_x),
        .s_box_max_y(s_box_max_y),
        .s_box_max_z(s_box_max_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_visible  (m_visible)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: check accepted requests, then pick next ready
    always @(posedge aclk) begin
        if (m_valid && m_ready)
            sb.check_result(m_visible);
        m_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog on cycles with no request moving on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic coord_t coord_between(int lo, int hi);
        return coord_t'(int'($urandom_range(hi - lo)) + lo);
    endfunction

    function automatic logic [MATRIX_WIDTH-1:0] q12_between(int lo, int hi);
        return MATRIX_WIDTH'(int'($urandom_range(hi - lo)) + lo);
    endfunction

    function automatic box_t make_box(coord_t x0, coord_t y0, coord_t z0,
                                      coord_t x1, coord_t y1, coord_t z1);
        box_t b;
        b.lo[AXIS_X] = x0;
        b.lo[AXIS_Y] = y0;
        b.lo[AXIS_Z] = z0;
        b.hi[AXIS_X] = x1;
        b.hi[AXIS_Y] = y1;
        b.hi[AXIS_Z] = z1;
        return b;
    endfunction

    // mostly small boxes and points near the view, some noise and inverted boxes
    function automatic box_t random_box();
        box_t b;
        int kind;
        coord_t c;
        coord_t e;
        coord_t t;
        kind = $urandom_range(99);
        for (int a = 0; a < AXIS_COUNT; a++) begin
            if (kind < 15) begin
                b.lo[a] = coord_t'($urandom);
                b.hi[a] = coord_t'($urandom);
            end else begin
                c = coord_between(-SPAN, SPAN);
                e = (kind < 35) ? coord_t'(0) : coord_t'($urandom_range(EXT_MAX));
                b.lo[a] = c - e;
                b.hi[a] = c + e;
                if (kind >= 90) begin
                    t = b.lo[a];
                    b.lo[a] = b.hi[a];
                    b.hi[a] = t;
                end
            end
        end
        return b;
    endfunction

    // perspective-like matrix: strong diagonal in x and y, w mostly from the offset
    function automatic cfg_bank_t camera_bank();
        cfg_bank_t bank;
        bank[REG_ROW_X_01] = {q12_between(-ONE_Q12 / 4, ONE_Q12 / 4),
                              q12_between(-ONE_Q12, ONE_Q12)};
        bank[REG_ROW_X_23] = {q12_between(-ONE_Q12 / 2, ONE_Q12 / 2),
                              q12_between(-ONE_Q12 / 4, ONE_Q12 / 4)};
        bank[REG_ROW_Y_01] = {q12_between(-ONE_Q12, ONE_Q12),
                              q12_between(-ONE_Q12 / 4, ONE_Q12 / 4)};
        bank[REG_ROW_Y_23] = {q12_between(-ONE_Q12 / 2, ONE_Q12 / 2),
                              q12_between(-ONE_Q12 / 4, ONE_Q12 / 4)};
        bank[REG_ROW_W_01] = {q12_between(-ONE_Q12 / 8, ONE_Q12 / 8),
                              q12_between(-ONE_Q12 / 8, ONE_Q12 / 8)};
        bank[REG_ROW_W_23] = {q12_between(ONE_Q12, 3 * ONE_Q12),
                              q12_between(-ONE_Q12, ONE_Q12)};
        return bank;
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // load all six registers, block idle
    task automatic write_matrix(input cfg_bank_t bank);
        for (int i = 0; i < REG_COUNT; i++)
            write_reg(REG_IDX_W'(i), bank[i]);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // offer one box after a random gap, return at the accepting edge
    task automatic send_box(input box_t b, input int gap_pct);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_box_min_x <= b.lo[AXIS_X];
        s_box_min_y <= b.lo[AXIS_Y];
        s_box_min_z <= b.lo[AXIS_Z];
        s_box_max_x <= b.hi[AXIS_X];
        s_box_max_y <= b.hi[AXIS_Y];
        s_box_max_z <= b.hi[AXIS_Z];
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_box(b);
    endtask

    // valid is dropped by the drain that always follows
    task automatic send_random(input int count, input int gap_pct);
        for (int i = 0; i < count; i++)
            send_box(random_box(), gap_pct);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic random_phase(input cfg_bank_t bank, input int gap_pct, input int stall_pct);
        write_matrix(bank);
        rx_stall_pct <= stall_pct;
        send_random(PHASE_ITEMS, gap_pct);
        wait_drained();
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset identity, so visible means |x|, |y| <= 1.0
        send_box(make_box(0, 0, 0, 0, 0, 0), 0);
        send_box(make_box(-ONE_Q16, -ONE_Q16, 0, ONE_Q16, ONE_Q16, 0), 0);
        send_box(make_box(0, 0, 0, ONE_Q16 + 1, 0, 0), 0);
        send_box(make_box(0, -ONE_Q16 - 1, 0, 0, 0, 0), 0);
        // min above max, corners taken as given
        send_box(make_box(ONE_Q16 / 2, ONE_Q16 / 2, 0, -ONE_Q16 / 2, -ONE_Q16 / 2, 0), 0);
        send_box(make_box(2 * ONE_Q16, 0, 0, -ONE_Q16 / 4, 0, 0), 0);
        send_box(make_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 0);
        send_box(make_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 0);
        send_box(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 0);
        send_box(make_box(0, 0, C_MIN, 0, 0, C_MAX), 0);
        wait_drained();

        // w taken from z alone, plus writes to unused indexes that must be dropped
        write_matrix({32'h0000_1000, 32'h0000_0000, RST_ROW_Y_23, RST_ROW_Y_01,
                      RST_ROW_X_23, RST_ROW_X_01});
        @(posedge aclk);
        write_reg(IDX_SPARE_FIRST, '1);
        write_reg(IDX_SPARE_LAST, '1);
        cfg_wr_en <= 1'b0;
        send_box(make_box(0, 0, 0, 0, 0, 0), 0);
        send_box(make_box(0, 0, ONE_Q16, 0, 0, ONE_Q16), 0);
        send_box(make_box(-ONE_Q16, 0, ONE_Q16, ONE_Q16, 0, ONE_Q16), 0);
        send_box(make_box(0, 0, -ONE_Q16, 0, 0, ONE_Q16), 0);
        send_box(make_box(ONE_Q16 / 2, 0, -ONE_Q16 / 2, ONE_Q16 / 2, 0, -ONE_Q16 / 2), 0);
        send_box(make_box(ONE_Q16 / 2, 0, -ONE_Q16 / 4, ONE_Q16 / 2, 0, -ONE_Q16 / 4), 0);
        wait_drained();

        // extreme matrices against extreme coordinates
        write_matrix(cfg_bank_t'({REG_COUNT{32'h7FFF_7FFF}}));
        send_box(make_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 0);
        send_box(make_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 0);
        send_box(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 0);
        wait_drained();
        write_matrix(cfg_bank_t'({REG_COUNT{32'h8000_8000}}));
        send_box(make_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 0);
        send_box(make_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 0);
        send_box(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 0);
        wait_drained();
        // all-zero matrix: w is zero everywhere
        write_matrix('0);
        send_box(make_box(0, 0, 0, 0, 0, 0), 0);
        wait_drained();

        // random phases over several matrices and idling mixes
        random_phase({RST_ROW_W_23, RST_ROW_W_01, RST_ROW_Y_23, RST_ROW_Y_01,
                      RST_ROW_X_23, RST_ROW_X_01}, 0, 0);
        random_phase(camera_bank(), 54, 0);
        random_phase(camera_bank(), 0, 54);
        random_phase(camera_bank(), 25, 25);
        random_phase(cfg_bank_t'({REG_COUNT{32'h7FFF_7FFF}}), 0, 0);
        random_phase(cfg_bank_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom}), 25, 25);
        random_phase(cfg_bank_t'({REG_COUNT{32'h8000_8000}}), 54, 0);

        // receiver holds off while the sender keeps offering, pipeline backs up
        write_matrix(camera_bank());
        rx_stall_pct <= 0;
        fork
            send_random(PHASE_ITEMS, 0);
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        join
        wait_drained();

        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        $display("checked %0d boxes (%0d visible) across %0d matrix settings,",
                 sb.checked, sb.visible_seen, settings_used);
        $display("with directed corner cases, random idling and a long receiver hold-off");
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
src/bfv_pkg.sv
src/bfv_products.sv
src/bfv_lane.sv
src/box_frustum_visibility.sv
verif/tb.sv
